// File: rtl/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types, register codes and letter/square helpers for the Playfair
// digram encryptor.
// ----------------------------------------------------------------------------
`default_nettype none

package pfe_pkg;

    // Square geometry
    localparam int CELLS    = 25;
    localparam int SIDE     = 5;
    localparam int LTR_W    = 5;
    localparam int POS_W    = 5;
    localparam int RC_W     = 3;
    localparam int CFG_W    = 60;
    localparam int CFG_IDX_W = 2;

    // Letter codes around the missing j
    localparam logic [LTR_W-1:0] LETTER_I   = 5'd8;
    localparam logic [LTR_W-1:0] LETTER_J   = 5'd9;
    localparam logic [LTR_W-1:0] PAD_RESET  = 5'd25;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SQUARE_LOW = 2'd0,
        REG_SQUARE_MID = 2'd1,
        REG_SQUARE_TOP = 2'd2,
        REG_PAD_LETTER = 2'd3
    } t_cfg_index;

    // Key square, cell k at bits 5k
    typedef logic [CELLS-1:0][LTR_W-1:0] t_square;

    typedef struct packed {
        logic [LTR_W-1:0] letter;
        logic             message_end;
    } t_in;

    typedef struct packed {
        logic [LTR_W-1:0] cipher_first;
        logic [LTR_W-1:0] cipher_second;
        logic             run_last;
        logic             message_done;
    } t_out;

    // Pair handed from the pairing stage to the cipher stage
    typedef struct packed {
        logic [LTR_W-1:0] a;
        logic [LTR_W-1:0] b;
        logic             dup;
        logic             msg_end;
    } t_pair;

    // Letter code to j-less square index
    function automatic logic [LTR_W-1:0] f_index_of_letter(logic [LTR_W-1:0] x);
        logic [LTR_W-1:0] r;
        if (x == LETTER_J) begin
            r = LETTER_I;
        end else if (x > LETTER_J) begin
            r = x - 5'd1;
        end else begin
            r = x;
        end
        return r;
    endfunction

    // Square value back to letter code, wraps at 5 bits
    function automatic logic [LTR_W-1:0] f_letter_of_value(logic [LTR_W-1:0] v);
        logic [LTR_W-1:0] r;
        if (v > LETTER_I) begin
            r = v + 5'd1;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Highest matching cell, cell 0 when nothing matches
    function automatic logic [POS_W-1:0] f_find_cell(t_square sq, logic [LTR_W-1:0] idx);
        logic [POS_W-1:0] pos;
        pos = '0;
        for (int c = 0; c < CELLS; c++) begin
            if (sq[c] == idx) begin
                pos = POS_W'(c);
            end
        end
        return pos;
    endfunction

    // Row of a cell position (position / 5 by range compare)
    function automatic logic [RC_W-1:0] f_row(logic [POS_W-1:0] pos);
        logic [RC_W-1:0] r;
        if (pos >= 5'd20) begin
            r = 3'd4;
        end else if (pos >= 5'd15) begin
            r = 3'd3;
        end else if (pos >= 5'd10) begin
            r = 3'd2;
        end else if (pos >= 5'd5) begin
            r = 3'd1;
        end else begin
            r = 3'd0;
        end
        return r;
    endfunction

    // Row times five as a shift and add
    function automatic logic [POS_W-1:0] f_times5(logic [RC_W-1:0] r);
        logic [POS_W-1:0] w;
        w = {2'b00, r};
        return (w << 2) + w;
    endfunction

    // Step one place around the side of the square
    function automatic logic [RC_W-1:0] f_inc5(logic [RC_W-1:0] x);
        logic [RC_W-1:0] r;
        if (x == 3'(SIDE - 1)) begin
            r = '0;
        end else begin
            r = x + 3'd1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/pfe_pair.sv
// ----------------------------------------------------------------------------
// pfe_pair
// Pairing stage: holds the first letter of a pair and registers each
// completed pair, with odd-end and doubled-letter padding already applied.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_pair (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire pfe_pkg::t_in             i_in,
    input  wire logic [pfe_pkg::LTR_W-1:0] i_pad,
    input  wire logic                     i_release,
    output logic                          o_pair_valid,
    output pfe_pkg::t_pair                o_pair
);

    logic                       r_valid;
    logic                       n_valid;
    pfe_pkg::t_pair             r_pair;
    pfe_pkg::t_pair             n_pair;
    logic [pfe_pkg::LTR_W-1:0]  r_held;
    logic                       r_held_valid;
    logic                       accept;
    logic                       complete;
    logic [pfe_pkg::LTR_W-1:0]  pa;
    logic [pfe_pkg::LTR_W-1:0]  pb;

    assign o_in_ready   = !r_valid || i_release;
    assign accept       = i_in_valid && o_in_ready;
    assign o_pair_valid = r_valid;
    assign o_pair       = r_pair;

    // Form the pair: held letter first, else the odd final letter with pad
    assign complete = r_held_valid || i_in.message_end;
    assign pa       = r_held_valid ? r_held : i_in.letter;
    assign pb       = r_held_valid ? i_in.letter : i_pad;

    // Doubled letters: both halves encrypt as (letter, pad)
    always_comb begin
        n_pair.a       = pa;
        n_pair.b       = (pa == pb) ? i_pad : pb;
        n_pair.dup     = (pa == pb);
        n_pair.msg_end = i_in.message_end;
        n_valid        = accept ? complete : (r_valid && !i_release);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_held_valid <= 1'b0;
            r_held       <= '0;
        end else begin
            r_valid <= n_valid;
            if (accept) begin
                if (complete) begin
                    r_held_valid <= 1'b0;
                end else begin
                    r_held_valid <= 1'b1;
                    r_held       <= i_in.letter;
                end
            end
        end
    end

    // Pair payload
    always_ff @(posedge i_clk) begin
        if (accept && complete) begin
            r_pair <= n_pair;
        end
    end

endmodule

`default_nettype wire

// File: rtl/pfe_lookup.sv
// ----------------------------------------------------------------------------
// pfe_lookup
// Cipher logic: locates both letters in the key square in parallel and
// applies the row, column and rectangle rules.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_lookup (
    input  wire pfe_pkg::t_square           i_square,
    input  wire logic [pfe_pkg::LTR_W-1:0]  i_a,
    input  wire logic [pfe_pkg::LTR_W-1:0]  i_b,
    output logic [pfe_pkg::LTR_W-1:0]       o_first,
    output logic [pfe_pkg::LTR_W-1:0]       o_second
);

    logic [pfe_pkg::POS_W-1:0] p1, p2;
    logic [pfe_pkg::RC_W-1:0]  r1, c1, r2, c2;
    logic [pfe_pkg::RC_W-1:0]  nr1, nc1, nr2, nc2;
    logic [pfe_pkg::POS_W-1:0] q1, q2;

    // Locate both letters
    always_comb begin
        p1 = pfe_pkg::f_find_cell(i_square, pfe_pkg::f_index_of_letter(i_a));
        p2 = pfe_pkg::f_find_cell(i_square, pfe_pkg::f_index_of_letter(i_b));
        r1 = pfe_pkg::f_row(p1);
        r2 = pfe_pkg::f_row(p2);
        c1 = pfe_pkg::RC_W'(p1 - pfe_pkg::f_times5(r1));
        c2 = pfe_pkg::RC_W'(p2 - pfe_pkg::f_times5(r2));
    end

    // Playfair rules
    always_comb begin
        nr1 = r1;
        nr2 = r2;
        nc1 = c1;
        nc2 = c2;
        if (r1 == r2) begin
            nc1 = pfe_pkg::f_inc5(c1);
            nc2 = pfe_pkg::f_inc5(c2);
        end else if (c1 == c2) begin
            nr1 = pfe_pkg::f_inc5(r1);
            nr2 = pfe_pkg::f_inc5(r2);
        end else begin
            nc1 = c2;
            nc2 = c1;
        end
        q1 = pfe_pkg::f_times5(nr1) + {2'b00, nc1};
        q2 = pfe_pkg::f_times5(nr2) + {2'b00, nc2};
    end

    assign o_first  = pfe_pkg::f_letter_of_value(i_square[q1]);
    assign o_second = pfe_pkg::f_letter_of_value(i_square[q2]);

endmodule

`default_nettype wire

// File: rtl/playfair_digram_encrypt.sv
// ----------------------------------------------------------------------------
// playfair_digram_encrypt
// Playfair digram encryptor with a software-loaded 5x5 key square.
// ----------------------------------------------------------------------------
// Takes one plaintext letter per cycle unless the output stalls. The first
// letter of each pair gives no result; the letter that completes a pair
// gives its digram through a pair register and then a result register. A
// doubled pair (also an odd final letter equal to the pad letter) gives two
// digrams and holds the input while the result register emits the second
// one. The user must write the key square and pad letter through the
// configuration port while the block is idle; the block does not check.
`default_nettype none

module playfair_digram_encrypt (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [pfe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [pfe_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire pfe_pkg::t_in                  i_in,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output pfe_pkg::t_out                      o_out
);

    logic [pfe_pkg::CFG_W-1:0] r_sq_low;
    logic [pfe_pkg::CFG_W-1:0] r_sq_mid;
    logic [pfe_pkg::LTR_W-1:0] r_sq_top;
    logic [pfe_pkg::LTR_W-1:0] r_pad;
    pfe_pkg::t_square          square;

    logic                      pair_valid;
    pfe_pkg::t_pair            pair;
    logic                      release_pair;
    logic                      out_open;
    logic                      load;
    logic                      last_half;
    logic [pfe_pkg::LTR_W-1:0] ct_first;
    logic [pfe_pkg::LTR_W-1:0] ct_second;

    logic                      r_out_valid;
    pfe_pkg::t_out             r_out;
    logic                      r_half;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_low <= '0;
            r_sq_mid <= '0;
            r_sq_top <= '0;
            r_pad    <= pfe_pkg::PAD_RESET;
        end else if (i_cfg_we) begin
            case (pfe_pkg::t_cfg_index'(i_cfg_index))
                pfe_pkg::REG_SQUARE_LOW: r_sq_low <= i_cfg_data;
                pfe_pkg::REG_SQUARE_MID: r_sq_mid <= i_cfg_data;
                pfe_pkg::REG_SQUARE_TOP: r_sq_top <= i_cfg_data[pfe_pkg::LTR_W-1:0];
                pfe_pkg::REG_PAD_LETTER: r_pad    <= i_cfg_data[pfe_pkg::LTR_W-1:0];
                default: ;
            endcase
        end
    end

    assign square = {r_sq_top, r_sq_mid, r_sq_low};

    // Pairing stage
    pfe_pair u_pair (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in         (i_in),
        .i_pad        (r_pad),
        .i_release    (release_pair),
        .o_pair_valid (pair_valid),
        .o_pair       (pair)
    );

    // Cipher lookup
    pfe_lookup u_lookup (
        .i_square (square),
        .i_a      (pair.a),
        .i_b      (pair.b),
        .o_first  (ct_first),
        .o_second (ct_second)
    );

    // Result register; a doubled pair loads twice before releasing
    assign out_open     = !r_out_valid || i_out_ready;
    assign load         = pair_valid && out_open;
    assign last_half    = !pair.dup || r_half;
    assign release_pair = load && last_half;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_half      <= 1'b0;
        end else begin
            r_out_valid <= load || (r_out_valid && !i_out_ready);
            if (load) begin
                r_half <= pair.dup && !r_half;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.cipher_first  <= ct_first;
            r_out.cipher_second <= ct_second;
            r_out.run_last      <= last_half;
            r_out.message_done  <= last_half && pair.msg_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef ASSERT_OFF
    // Second half pending only while a doubled pair sits in the pair stage
    a_half_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> (pair_valid && pair.dup))
        else $error("half flag without doubled pair");

    // A first-half item on the output means its second half is pending
    a_first_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.run_last) |-> r_half)
        else $error("first half shown without pending second half");

    // Taking a first-half item brings the second half next cycle
    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_out.run_last) |=>
        (o_out_valid && o_out.run_last))
        else $error("second half of doubled pair missing");

    // End of message only flagged on the last item of a run
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.message_done) |-> o_out.run_last)
        else $error("message done on non-last item");
`endif

endmodule

`default_nettype wire
